// File: design/line_intersection_classifier_defines.svh
// ----------------------------------------------------------------------------
// Line intersection classifier assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_INTERSECTION_CLASSIFIER_DEFINES_SVH
`define LINE_INTERSECTION_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF

// check a plain condition every cycle
`define LIC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a same-cycle implication
`define LIC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check a next-cycle implication
`define LIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LIC_ASSERT(label, clk, rst, prop, msg)
`define LIC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define LIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: design/lic_pkg.sv
// ----------------------------------------------------------------------------
// Line intersection classifier package
// Shared widths, reset values, register indexes, sequencer states and types.
// ----------------------------------------------------------------------------
`default_nettype none

package lic_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int DIST_WIDTH_DEFAULT  = 24;

   localparam int AVG_WIDTH = 17;
   localparam logic [AVG_WIDTH-1:0] Q_ONE = 17'd65536;

   localparam int NEAR_LIMIT_RESET       = 256;
   localparam int FRONT_LOW_RESET        = 384;
   localparam int FRONT_HIGH_RESET       = 768;
   localparam int SIDE_THRESHOLD_RESET   = 26214;
   localparam int CENTER_THRESHOLD_RESET = 32768;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NEAR_LIMIT       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRONT_LOW        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRONT_HIGH       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIDE_THRESHOLD   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_THRESHOLD = 3'd4;

   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef logic [1:0] lic_slot_type;
   localparam lic_slot_type SLOT_LEFT   = 2'd0;
   localparam lic_slot_type SLOT_CENTER = 2'd1;
   localparam lic_slot_type SLOT_RIGHT  = 2'd2;
   localparam lic_slot_type SLOT_FRONT  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRAVEL,
      ST_WINDOW,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_DONE
   } lic_state_type;

   typedef struct packed {
      logic [AVG_WIDTH-1:0] left;
      logic [AVG_WIDTH-1:0] center;
      logic [AVG_WIDTH-1:0] right;
      logic [AVG_WIDTH-1:0] front;
   } lic_avg_type;

endpackage

`default_nettype wire

// File: design/lic_divider.sv
// ----------------------------------------------------------------------------
// Line intersection classifier divider
// Restoring divider, one quotient bit per cycle, quotient known to fit the
// average width.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_divider #(
   parameter int DEN_WIDTH = lic_pkg::COUNT_WIDTH_DEFAULT + 1,
   localparam int NUM_WIDTH = DEN_WIDTH + lic_pkg::AVG_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [NUM_WIDTH-1:0]           numer,
   input  wire logic [DEN_WIDTH-1:0]           denom,
   output logic                                busy,
   output logic                                done,
   output logic [lic_pkg::AVG_WIDTH-1:0]       quot
);

   localparam int QW     = lic_pkg::AVG_WIDTH;
   localparam int STEP_W = $clog2(QW);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QW - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DEN_WIDTH-1:0] rem_ff, rem_in;
   logic [DEN_WIDTH-1:0] den_ff, den_in;
   logic [QW-1:0]        q_ff, q_in;

   logic [DEN_WIDTH:0]   trial;
   logic [DEN_WIDTH:0]   diff;
   logic                 ge;

   assign trial = {rem_ff, q_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = numer[NUM_WIDTH-1:QW];
         den_in  = denom;
         q_in    = numer[QW-1:0];
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
         q_in    = {q_ff[QW-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

// File: design/lic_sequencer.sv
// ----------------------------------------------------------------------------
// Line intersection classifier sequencer
// Tracks travelled distance and steps the running averages through one
// shared multiply and divide path.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_intersection_classifier_defines.svh"

module lic_sequencer #(
   parameter int COUNT_WIDTH = lic_pkg::COUNT_WIDTH_DEFAULT,
   parameter int DIST_WIDTH  = lic_pkg::DIST_WIDTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic                    cmd,
   input  wire logic [DIST_WIDTH-1:0]   distance,
   input  wire logic                    left_hit,
   input  wire logic                    center_hit,
   input  wire logic                    right_hit,
   input  wire logic [DIST_WIDTH-1:0]   near_limit,
   input  wire logic [DIST_WIDTH-1:0]   front_low,
   input  wire logic [DIST_WIDTH-1:0]   front_high,
   input  wire logic                    ack,
   output logic                         idle,
   output logic                         done,
   output logic signed [DIST_WIDTH:0]   travelled,
   output lic_pkg::lic_avg_type         avgs
);

   localparam int AW      = lic_pkg::AVG_WIDTH;
   localparam int DEN_W   = COUNT_WIDTH + 1;
   localparam int PROD_W  = COUNT_WIDTH + AW;
   localparam int NUM_W   = DEN_W + AW;

   lic_pkg::lic_state_type state_ff, state_in;
   lic_pkg::lic_slot_type  slot_ff;

   logic                      cmd_ff;
   logic [DIST_WIDTH-1:0]     dist_ff;
   logic                      hit_ff [3];
   logic [DIST_WIDTH-1:0]     start_ff;
   logic signed [DIST_WIDTH:0] travelled_ff;
   logic                      old_near_ff;
   logic [COUNT_WIDTH-1:0]    count_ff [3];
   logic [AW-1:0]             avg_ff [4];
   logic [PROD_W-1:0]         prod_ff;

   logic [1:0]                cidx;
   logic [COUNT_WIDTH-1:0]    count_sel;
   logic [AW-1:0]             avg_sel;
   logic                      hit_sel;
   logic [DEN_W-1:0]          denom;
   logic [NUM_W-1:0]          numer;
   logic                      trav_le_near;
   logic                      trav_in_front;
   logic                      div_start;
   logic                      div_busy;
   logic                      div_done;
   logic [AW-1:0]             div_quot;

   assign cidx      = (slot_ff == lic_pkg::SLOT_FRONT) ? lic_pkg::SLOT_CENTER : slot_ff;
   assign count_sel = count_ff[cidx];
   assign avg_sel   = avg_ff[slot_ff];
   assign hit_sel   = hit_ff[cidx];
   assign denom     = {1'b0, count_sel} + 1'b1;
   assign numer     = NUM_W'(prod_ff) + NUM_W'(hit_sel ? lic_pkg::Q_ONE : '0)
                      + NUM_W'(denom >> 1);

   assign trav_le_near  = travelled_ff <= $signed({1'b0, near_limit});
   assign trav_in_front = (travelled_ff >= $signed({1'b0, front_low}))
                          && (travelled_ff <= $signed({1'b0, front_high}));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lic_pkg::ST_IDLE: begin
            if (start) state_in = lic_pkg::ST_TRAVEL;
         end
         lic_pkg::ST_TRAVEL: begin
            state_in = (cmd_ff == lic_pkg::CMD_SAMPLE) ? lic_pkg::ST_WINDOW
                                                       : lic_pkg::ST_DONE;
         end
         lic_pkg::ST_WINDOW: begin
            state_in = (trav_le_near || trav_in_front) ? lic_pkg::ST_MUL
                                                       : lic_pkg::ST_DONE;
         end
         lic_pkg::ST_MUL: state_in = lic_pkg::ST_ADD;
         lic_pkg::ST_ADD: state_in = lic_pkg::ST_DIV;
         lic_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = (slot_ff == lic_pkg::SLOT_RIGHT || slot_ff == lic_pkg::SLOT_FRONT)
                          ? lic_pkg::ST_DONE : lic_pkg::ST_MUL;
            end
         end
         lic_pkg::ST_DONE: begin
            if (ack) state_in = lic_pkg::ST_IDLE;
         end
         default: state_in = lic_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      idle      = 1'b0;
      done      = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         lic_pkg::ST_IDLE: idle      = 1'b1;
         lic_pkg::ST_ADD:  div_start = 1'b1;
         lic_pkg::ST_DONE: done      = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lic_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == lic_pkg::ST_IDLE && start) begin
         cmd_ff    <= cmd;
         dist_ff   <= distance;
         hit_ff[0] <= left_hit;
         hit_ff[1] <= center_hit;
         hit_ff[2] <= right_hit;
      end
      if (state_ff == lic_pkg::ST_MUL) begin
         prod_ff <= PROD_W'(count_sel) * PROD_W'(avg_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= lic_pkg::SLOT_LEFT;
         start_ff     <= '0;
         travelled_ff <= '0;
         old_near_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) count_ff[i] <= '0;
         for (int i = 0; i < 4; i++) avg_ff[i] <= '0;
      end else begin
         unique case (state_ff)
            lic_pkg::ST_TRAVEL: begin
               if (cmd_ff == lic_pkg::CMD_SAMPLE) begin
                  old_near_ff  <= trav_le_near;
                  travelled_ff <= $signed({1'b0, dist_ff}) - $signed({1'b0, start_ff});
               end else begin
                  start_ff     <= dist_ff;
                  travelled_ff <= '0;
               end
            end
            lic_pkg::ST_WINDOW: begin
               if (old_near_ff && !trav_le_near) count_ff[lic_pkg::SLOT_CENTER] <= '0;
               slot_ff <= trav_le_near ? lic_pkg::SLOT_LEFT : lic_pkg::SLOT_FRONT;
            end
            lic_pkg::ST_DIV: begin
               if (div_done) begin
                  avg_ff[slot_ff] <= div_quot;
                  if (count_sel != '1) count_ff[cidx] <= count_sel + 1'b1;
                  slot_ff <= slot_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   lic_divider #(
      .DEN_WIDTH (DEN_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer),
      .denom (denom),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign travelled   = travelled_ff;
   assign avgs.left   = avg_ff[lic_pkg::SLOT_LEFT];
   assign avgs.center = avg_ff[lic_pkg::SLOT_CENTER];
   assign avgs.right  = avg_ff[lic_pkg::SLOT_RIGHT];
   assign avgs.front  = avg_ff[lic_pkg::SLOT_FRONT];

   `LIC_ASSERT_IMPL(a_idle_div_quiet, clock, reset, state_ff == lic_pkg::ST_IDLE, !div_busy, "divider busy while idle")
   `LIC_ASSERT_IMPL(a_div_done_in_div, clock, reset, div_done, state_ff == lic_pkg::ST_DIV, "divider done outside divide state")
   `LIC_ASSERT(a_avg_bounded, clock, reset, (avg_ff[0] <= lic_pkg::Q_ONE) && (avg_ff[1] <= lic_pkg::Q_ONE) && (avg_ff[2] <= lic_pkg::Q_ONE) && (avg_ff[3] <= lic_pkg::Q_ONE), "average above one")
   `LIC_ASSERT_NEXT(a_start_zeroes, clock, reset, state_ff == lic_pkg::ST_TRAVEL && cmd_ff == lic_pkg::CMD_START, travelled_ff == '0, "start item left travelled nonzero")

endmodule

`default_nettype wire

// File: design/line_intersection_classifier.sv
// ----------------------------------------------------------------------------
// Line intersection classifier
// Classifies the crossing reached by a line follower from running averages
// of its left, center and right line sensors over travelled distance.
// ----------------------------------------------------------------------------
// Usage: items enter on the req_ channel (valid/ready). cmd 0 starts a
// segment at req_distance; cmd 1 is one sample of the three sensors. Every
// item yields exactly one item on the rsp_ channel with the black flags,
// intersection flag, crossing type and finished flag.
// Registers are written through csr_write_en/csr_index/csr_wdata; the user
// must write them only while idle, which the block itself does not enforce.
// A start item and a sample outside both windows update no average; a
// front-window sample runs one average update and a near-window sample
// three, back to back. Each update runs on the one shared multiply/divide
// path (one multiply, one add, 17 divide steps, one write-back).
// req_ready is high only while the sequencer is idle; one item is in work
// at a time, and the next is taken while a finished item waits in the
// output register.
// Reset (synchronous, active high) clears counts, averages, start point and
// travelled distance, and loads the default limits and thresholds.
// When rsp_ready is low the finished item holds in the output register and
// the sequencer waits with the next result until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module line_intersection_classifier #(
   parameter int COUNT_WIDTH = lic_pkg::COUNT_WIDTH_DEFAULT,
   parameter int DIST_WIDTH  = lic_pkg::DIST_WIDTH_DEFAULT,
   localparam int CSR_WIDTH  = (DIST_WIDTH > lic_pkg::AVG_WIDTH) ? DIST_WIDTH
                                                                 : lic_pkg::AVG_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_cmd,
   input  wire logic [DIST_WIDTH-1:0]               req_distance,
   input  wire logic                                req_left_hit,
   input  wire logic                                req_center_hit,
   input  wire logic                                req_right_hit,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_finished,
   output logic                                     rsp_is_crossing,
   output logic [2:0]                               rsp_crossing_type,
   output logic                                     rsp_left_black,
   output logic                                     rsp_right_black,
   output logic                                     rsp_center_black,
   output logic                                     rsp_front_black,
   input  wire logic                                csr_write_en,
   input  wire logic [lic_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_WIDTH-1:0]                csr_wdata
);

   localparam int AW = lic_pkg::AVG_WIDTH;

   localparam logic [2:0] TYPE_LRF   = 3'd0;
   localparam logic [2:0] TYPE_LF    = 3'd1;
   localparam logic [2:0] TYPE_RF    = 3'd2;
   localparam logic [2:0] TYPE_LR    = 3'd3;
   localparam logic [2:0] TYPE_L     = 3'd4;
   localparam logic [2:0] TYPE_R     = 3'd5;
   localparam logic [2:0] TYPE_OTHER = 3'd6;

   logic [DIST_WIDTH-1:0] near_limit_ff;
   logic [DIST_WIDTH-1:0] front_low_ff;
   logic [DIST_WIDTH-1:0] front_high_ff;
   logic [AW-1:0]         side_thr_ff;
   logic [AW-1:0]         center_thr_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       finished_ff;
   logic       is_crossing_ff;
   logic [2:0] type_ff;
   logic       left_black_ff;
   logic       right_black_ff;
   logic       center_black_ff;
   logic       front_black_ff;

   logic                       seq_idle;
   logic                       seq_done;
   logic                       seq_ack;
   logic signed [DIST_WIDTH:0] travelled;
   lic_pkg::lic_avg_type       avgs;

   logic       bl, br, bc, bf, fin;
   logic [2:0] ctype;

   assign req_ready = seq_idle;
   assign seq_ack   = seq_done && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         near_limit_ff <= DIST_WIDTH'(lic_pkg::NEAR_LIMIT_RESET);
         front_low_ff  <= DIST_WIDTH'(lic_pkg::FRONT_LOW_RESET);
         front_high_ff <= DIST_WIDTH'(lic_pkg::FRONT_HIGH_RESET);
         side_thr_ff   <= AW'(lic_pkg::SIDE_THRESHOLD_RESET);
         center_thr_ff <= AW'(lic_pkg::CENTER_THRESHOLD_RESET);
      end else if (csr_write_en) begin
         unique case (csr_index)
            lic_pkg::CSR_NEAR_LIMIT:       near_limit_ff <= csr_wdata[DIST_WIDTH-1:0];
            lic_pkg::CSR_FRONT_LOW:        front_low_ff  <= csr_wdata[DIST_WIDTH-1:0];
            lic_pkg::CSR_FRONT_HIGH:       front_high_ff <= csr_wdata[DIST_WIDTH-1:0];
            lic_pkg::CSR_SIDE_THRESHOLD:   side_thr_ff   <= csr_wdata[AW-1:0];
            lic_pkg::CSR_CENTER_THRESHOLD: center_thr_ff <= csr_wdata[AW-1:0];
            default: ;
         endcase
      end
   end

   lic_sequencer #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .DIST_WIDTH  (DIST_WIDTH)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .start      (req_valid && req_ready),
      .cmd        (req_cmd),
      .distance   (req_distance),
      .left_hit   (req_left_hit),
      .center_hit (req_center_hit),
      .right_hit  (req_right_hit),
      .near_limit (near_limit_ff),
      .front_low  (front_low_ff),
      .front_high (front_high_ff),
      .ack        (seq_ack),
      .idle       (seq_idle),
      .done       (seq_done),
      .travelled  (travelled),
      .avgs       (avgs)
   );

   always_comb begin
      bl  = avgs.left >= side_thr_ff;
      br  = avgs.right >= side_thr_ff;
      bc  = avgs.center > center_thr_ff;
      bf  = avgs.front > center_thr_ff;
      fin = travelled > $signed({1'b0, front_high_ff});
      priority if (bl && br && bf)   ctype = TYPE_LRF;
      else if (bl && !br && bf)      ctype = TYPE_LF;
      else if (!bl && br && bf)      ctype = TYPE_RF;
      else if (bl && br && !bf)      ctype = TYPE_LR;
      else if (bl && !br && !bf)     ctype = TYPE_L;
      else if (!bl && br && !bf)     ctype = TYPE_R;
      else                           ctype = TYPE_OTHER;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seq_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ack) begin
         finished_ff     <= fin;
         is_crossing_ff  <= bl || br || !bc || !bf;
         type_ff         <= ctype;
         left_black_ff   <= bl;
         right_black_ff  <= br;
         center_black_ff <= bc;
         front_black_ff  <= bf;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_finished      = finished_ff;
   assign rsp_is_crossing   = is_crossing_ff;
   assign rsp_crossing_type = type_ff;
   assign rsp_left_black    = left_black_ff;
   assign rsp_right_black   = right_black_ff;
   assign rsp_center_black  = center_black_ff;
   assign rsp_front_black   = front_black_ff;

endmodule

`default_nettype wire
